// ===== rtl/pmul_pkg.sv =====
// ----------------------------------------------------------------------------
// pmul_pkg
// Shared types and constants of the polynomial multiply core.
// ----------------------------------------------------------------------------
package pmul_pkg;

   localparam int MAX_TERMS   = 16;
   localparam int TERM_ADDR_W = $clog2(MAX_TERMS);
   localparam int COUNT_W     = $clog2(MAX_TERMS + 1);
   localparam int SLOT_COUNT  = 2 * MAX_TERMS - 1;
   localparam int SLOT_ADDR_W = $clog2(SLOT_COUNT);

   localparam int COEF_W     = 64;
   localparam int HALF_W     = COEF_W / 2;
   localparam int DEGREE_W   = 5;
   localparam int RSP_DATA_W = ((COEF_W + DEGREE_W + 1 + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - COEF_W - DEGREE_W - 1;

   // request kinds carried on tuser
   localparam logic REQ_FIRST  = 1'b0;
   localparam logic REQ_SECOND = 1'b1;

   // multiply-accumulate phases of the shared unit
   localparam logic [1:0] MAC_PH_LL  = 2'd0;
   localparam logic [1:0] MAC_PH_LH  = 2'd1;
   localparam logic [1:0] MAC_PH_HL  = 2'd2;
   localparam logic [1:0] MAC_PH_SUM = 2'd3;

   typedef enum logic [7:0] {
      ST_LOAD  = 8'b0000_0001,
      ST_START = 8'b0000_0010,
      ST_FETCH = 8'b0000_0100,
      ST_MAC   = 8'b0000_1000,
      ST_TRIM  = 8'b0001_0000,
      ST_ERD   = 8'b0010_0000,
      ST_ECAP  = 8'b0100_0000,
      ST_EWAIT = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic       en;
      logic [1:0] phase;
   } mac_ctl_type;

endpackage

// ===== rtl/pmul_ram.sv =====
// ----------------------------------------------------------------------------
// pmul_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module pmul_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pmul_mac.sv =====
// ----------------------------------------------------------------------------
// pmul_mac
// Shared multiply-accumulate unit: 64-bit wrapped product from three
// 32x32 partial products, added onto a slot value over four phases.
// ----------------------------------------------------------------------------
module pmul_mac (
   input  logic                             clock,
   input  pmul_pkg::mac_ctl_type            mac_ctl,
   input  logic [pmul_pkg::COEF_W-1:0]      op_a,
   input  logic [pmul_pkg::COEF_W-1:0]      op_b,
   input  logic [pmul_pkg::COEF_W-1:0]      base,
   output logic [pmul_pkg::COEF_W-1:0]      sum
);

   logic [pmul_pkg::HALF_W-1:0] mul_a;
   logic [pmul_pkg::HALF_W-1:0] mul_b;
   logic [pmul_pkg::COEF_W-1:0] prod_ff;
   logic [pmul_pkg::COEF_W-1:0] prod_in;
   logic [pmul_pkg::COEF_W-1:0] acc_ff;
   logic [pmul_pkg::COEF_W-1:0] acc_in;
   logic [pmul_pkg::COEF_W-1:0] term;

   always_comb begin
      case (mac_ctl.phase)
         pmul_pkg::MAC_PH_LH: begin
            mul_a = op_a[pmul_pkg::HALF_W-1:0];
            mul_b = op_b[pmul_pkg::COEF_W-1:pmul_pkg::HALF_W];
         end
         pmul_pkg::MAC_PH_HL: begin
            mul_a = op_a[pmul_pkg::COEF_W-1:pmul_pkg::HALF_W];
            mul_b = op_b[pmul_pkg::HALF_W-1:0];
         end
         default: begin
            mul_a = op_a[pmul_pkg::HALF_W-1:0];
            mul_b = op_b[pmul_pkg::HALF_W-1:0];
         end
      endcase
   end

   assign prod_in = pmul_pkg::COEF_W'(mul_a) * pmul_pkg::COEF_W'(mul_b);

   // low partial product adds as is, the cross terms land in the upper half
   assign term = (mac_ctl.phase == pmul_pkg::MAC_PH_LH) ? prod_ff :
                 {prod_ff[pmul_pkg::HALF_W-1:0], {pmul_pkg::HALF_W{1'b0}}};

   assign sum    = acc_ff + term;
   assign acc_in = (mac_ctl.phase == pmul_pkg::MAC_PH_LL) ? base : sum;

   always_ff @(posedge clock) begin
      if (mac_ctl.en) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

// ===== rtl/polynomial_multiply_core.sv =====
// ----------------------------------------------------------------------------
// polynomial_multiply_core
// Direct-convolution product of two integer polynomials, trimmed and
// streamed out lowest degree first.
// ----------------------------------------------------------------------------
// coefficient loads are accepted one per cycle while the core is loading
// after the final load, one shared 32x32 multiplier works through
//   four phases plus one operand fetch for each coefficient pair
// each result then passes through a slot read, a capture and a wait for the result side
// synchronous reset returns to loading with empty stores and no results
module polynomial_multiply_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pmul_pkg::COEF_W-1:0]       req_tdata,  // [63:0] coef_value
   input  logic                              req_tuser,  // [0] req_type
   input  logic                              req_tlast,  // is_last
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pmul_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [63:0] prod_coef,
                                                         // [68:64] prod_degree,
                                                         // [69] overflow, [71:70] zero
   output logic                              rsp_tlast   // last_coef
);

   pmul_pkg::state_type state_ff, state_in;

   logic [pmul_pkg::COUNT_W-1:0]     fcnt_ff, fcnt_in;
   logic [pmul_pkg::COUNT_W-1:0]     scnt_ff, scnt_in;
   logic                             drop_ff, drop_in;
   logic [pmul_pkg::TERM_ADDR_W-1:0] i_ff, i_in;
   logic [pmul_pkg::TERM_ADDR_W-1:0] j_ff, j_in;
   logic [pmul_pkg::SLOT_ADDR_W-1:0] slot_ff, slot_in;
   logic [1:0]                       phase_ff, phase_in;
   logic [pmul_pkg::SLOT_ADDR_W-1:0] k_ff, k_in;
   logic [pmul_pkg::SLOT_ADDR_W-1:0] top_ff, top_in;
   logic [pmul_pkg::SLOT_COUNT-1:0]  valid_ff, valid_in;
   logic [pmul_pkg::SLOT_COUNT-1:0]  nz_ff, nz_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [pmul_pkg::RSP_DATA_W-1:0]  rsp_data_ff;
   logic                             rsp_last_ff;

   logic                             req_accept;
   logic                             a_wr_en;
   logic [pmul_pkg::TERM_ADDR_W-1:0] a_wr_addr;
   logic [pmul_pkg::COEF_W-1:0]      a_wr_data;
   logic                             b_wr_en;
   logic                             fetch;
   logic                             slot_rd_en;
   logic [pmul_pkg::SLOT_ADDR_W-1:0] slot_rd_addr;
   logic [pmul_pkg::SLOT_ADDR_W-1:0] slot_sum;
   logic                             slot_wr_en;
   logic                             cap;
   logic [pmul_pkg::SLOT_ADDR_W-1:0] top_calc;

   logic [pmul_pkg::COEF_W-1:0]      a_rd_data;
   logic [pmul_pkg::COEF_W-1:0]      b_rd_data;
   logic [pmul_pkg::COEF_W-1:0]      slot_rd_data;
   logic [pmul_pkg::COEF_W-1:0]      mac_base;
   logic [pmul_pkg::COEF_W-1:0]      mac_sum;
   pmul_pkg::mac_ctl_type            mac_ctl;

   assign req_tready = (state_ff == pmul_pkg::ST_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign slot_sum   = pmul_pkg::SLOT_ADDR_W'(i_ff) + pmul_pkg::SLOT_ADDR_W'(j_ff);
   assign mac_base   = valid_ff[slot_ff] ? slot_rd_data : '0;
   assign mac_ctl.en    = (state_ff == pmul_pkg::ST_MAC);
   assign mac_ctl.phase = phase_ff;

   // highest slot still non-zero, degree zero when all are zero
   always_comb begin
      top_calc = '0;
      for (int s = 0; s < pmul_pkg::SLOT_COUNT; s++) begin
         if (nz_ff[s]) begin
            top_calc = pmul_pkg::SLOT_ADDR_W'(s);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      fcnt_in      = fcnt_ff;
      scnt_in      = scnt_ff;
      drop_in      = drop_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      slot_in      = slot_ff;
      phase_in     = phase_ff;
      k_in         = k_ff;
      top_in       = top_ff;
      valid_in     = valid_ff;
      nz_in        = nz_ff;
      rsp_valid_in = rsp_valid_ff;
      a_wr_en      = 1'b0;
      a_wr_addr    = fcnt_ff[pmul_pkg::TERM_ADDR_W-1:0];
      a_wr_data    = req_tdata;
      b_wr_en      = 1'b0;
      fetch        = 1'b0;
      slot_rd_en   = 1'b0;
      slot_rd_addr = slot_sum;
      slot_wr_en   = 1'b0;
      cap          = 1'b0;
      case (state_ff)
         pmul_pkg::ST_LOAD: begin
            if (req_accept) begin
               if (req_tuser == pmul_pkg::REQ_FIRST) begin
                  if (fcnt_ff < pmul_pkg::COUNT_W'(pmul_pkg::MAX_TERMS)) begin
                     a_wr_en = 1'b1;
                     fcnt_in = fcnt_ff + 1'b1;
                  end else begin
                     drop_in = 1'b1;
                  end
               end else begin
                  if (scnt_ff < pmul_pkg::COUNT_W'(pmul_pkg::MAX_TERMS)) begin
                     b_wr_en = 1'b1;
                     scnt_in = scnt_ff + 1'b1;
                  end else begin
                     drop_in = 1'b1;
                  end
                  if (req_tlast) begin
                     state_in = pmul_pkg::ST_START;
                  end
               end
            end
         end
         pmul_pkg::ST_START: begin
            // an empty first list stands for the single coefficient zero
            if (fcnt_ff == '0) begin
               a_wr_en   = 1'b1;
               a_wr_addr = '0;
               a_wr_data = '0;
               fcnt_in   = pmul_pkg::COUNT_W'(1);
            end
            i_in     = '0;
            j_in     = '0;
            state_in = pmul_pkg::ST_FETCH;
         end
         pmul_pkg::ST_FETCH: begin
            fetch      = 1'b1;
            slot_rd_en = 1'b1;
            slot_in    = slot_sum;
            phase_in   = pmul_pkg::MAC_PH_LL;
            state_in   = pmul_pkg::ST_MAC;
         end
         pmul_pkg::ST_MAC: begin
            phase_in = phase_ff + 1'b1;
            if (phase_ff == pmul_pkg::MAC_PH_SUM) begin
               slot_wr_en        = 1'b1;
               valid_in[slot_ff] = 1'b1;
               nz_in[slot_ff]    = (mac_sum != '0);
               state_in          = pmul_pkg::ST_FETCH;
               if (pmul_pkg::COUNT_W'(j_ff) == fcnt_ff - 1'b1) begin
                  j_in = '0;
                  if (pmul_pkg::COUNT_W'(i_ff) == scnt_ff - 1'b1) begin
                     state_in = pmul_pkg::ST_TRIM;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         pmul_pkg::ST_TRIM: begin
            top_in   = top_calc;
            k_in     = '0;
            state_in = pmul_pkg::ST_ERD;
         end
         pmul_pkg::ST_ERD: begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = k_ff;
            state_in     = pmul_pkg::ST_ECAP;
         end
         pmul_pkg::ST_ECAP: begin
            cap          = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = pmul_pkg::ST_EWAIT;
         end
         pmul_pkg::ST_EWAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (k_ff == top_ff) begin
                  fcnt_in  = '0;
                  scnt_in  = '0;
                  drop_in  = 1'b0;
                  valid_in = '0;
                  nz_in    = '0;
                  state_in = pmul_pkg::ST_LOAD;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = pmul_pkg::ST_ERD;
               end
            end
         end
         default: begin
            state_in = pmul_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pmul_pkg::ST_LOAD;
         fcnt_ff      <= '0;
         scnt_ff      <= '0;
         drop_ff      <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         slot_ff      <= '0;
         phase_ff     <= '0;
         k_ff         <= '0;
         top_ff       <= '0;
         valid_ff     <= '0;
         nz_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fcnt_ff      <= fcnt_in;
         scnt_ff      <= scnt_in;
         drop_ff      <= drop_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         slot_ff      <= slot_in;
         phase_ff     <= phase_in;
         k_ff         <= k_in;
         top_ff       <= top_in;
         valid_ff     <= valid_in;
         nz_ff        <= nz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // never-written slots read as zero
   always_ff @(posedge clock) begin
      if (cap) begin
         rsp_data_ff <= {pmul_pkg::RSP_PAD_W'(0), drop_ff,
                         pmul_pkg::DEGREE_W'(k_ff),
                         valid_ff[k_ff] ? slot_rd_data : {pmul_pkg::COEF_W{1'b0}}};
         rsp_last_ff <= (k_ff == top_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   pmul_ram #(
      .WIDTH (pmul_pkg::COEF_W),
      .DEPTH (pmul_pkg::MAX_TERMS)
   ) u_first_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (a_wr_data),
      .rd_en   (fetch),
      .rd_addr (j_ff),
      .rd_data (a_rd_data)
   );

   pmul_ram #(
      .WIDTH (pmul_pkg::COEF_W),
      .DEPTH (pmul_pkg::MAX_TERMS)
   ) u_second_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (scnt_ff[pmul_pkg::TERM_ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_en   (fetch),
      .rd_addr (i_ff),
      .rd_data (b_rd_data)
   );

   pmul_ram #(
      .WIDTH (pmul_pkg::COEF_W),
      .DEPTH (pmul_pkg::SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_ff),
      .wr_data (mac_sum),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   pmul_mac u_mac (
      .clock   (clock),
      .mac_ctl (mac_ctl),
      .op_a    (a_rd_data),
      .op_b    (b_rd_data),
      .base    (mac_base),
      .sum     (mac_sum)
   );

endmodule

// ===== rtl/pmul_checker.sv =====
// ----------------------------------------------------------------------------
// pmul_checker
// Port-level checks of the polynomial multiply core, bound to the top level.
// ----------------------------------------------------------------------------
module pmul_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              req_tuser,
   input logic                              req_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [pmul_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tlast
);

   // loading and emitting never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request side ready while a result is pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result transaction changed");

   // the final second-polynomial transaction starts the multiply
   a_job_start: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == pmul_pkg::REQ_SECOND) && req_tlast
      |=> !req_tready)
      else $error("still loading after the final coefficient");

   a_job_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("not back to loading after the last result");

   a_next_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !req_tready && !rsp_tvalid)
      else $error("unexpected state after an intermediate result");

endmodule

bind polynomial_multiply_core pmul_checker u_pmul_checker (.*);
